@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the list manager checkers.
// Each use expands to one labeled concurrent assertion on the rising clock edge,
// switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DLNL_CHK_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DLNL_CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/dlnl_pkg.sv @@
`timescale 1ns / 1ps

package dlnl_pkg;

   // default geometry
   localparam int DLNL_NODES = 256;
   localparam int DLNL_LISTS = 4;

   // field widths
   localparam int OP_W    = 3;
   localparam int LID_W   = 2;
   localparam int NODE_W  = 8;
   localparam int CNT_W   = 9;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // request codes
   localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;
   localparam logic [OP_W-1:0] OP_INIT      = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [LID_W-1:0]  list_id;
      logic [NODE_W-1:0] node_index;
      logic [CNT_W-1:0]  init_count;
   } req_word_type;

   typedef struct packed {
      logic [NODE_W-1:0] result_node;
      logic              result_valid;
      logic [CNT_W-1:0]  list_count;
      logic              list_empty;
   } rsp_word_type;

   // saturating count steps
   function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] cnt_down(input logic [CNT_W-1:0] c);
      return (c == '0) ? c : c - 1'b1;
   endfunction

endpackage

@@ rtl/core/dlnl_ram.sv @@
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module dlnl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/doubly_linked_node_list_manager.sv @@
`timescale 1ns / 1ps
// Flow: a request word and its link reads are registered when taken; the result word is
//   registered in the execute step once the output slot is free. Init of N > 1 nodes
//   then walks, chaining one node per cycle while the output slot is free. One word is
//   in flight at a time (accept/read, then modify/write of the link RAMs).
// Reset: all lists empty with count 0; link RAMs and head/tail pointers are not cleared
//   and need no clearing pass.
module doubly_linked_node_list_manager import dlnl_pkg::*; #(
   parameter int NODES     = DLNL_NODES,
   parameter int NUM_LISTS = DLNL_LISTS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int NW = $clog2(NODES);
   localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,   // waiting for a request word
      ST_EXEC = 3'b010,   // link data back from RAM: modify, write, respond
      ST_WALK = 3'b100    // init: chain one more node per cycle while output is free
   } state_type;

   state_type state_ff, state_in;

   // request held for the execute step
   logic [OP_W-1:0]  typ_ff;
   logic [LW-1:0]    lid_ff;
   logic [NW-1:0]    node_ff;
   logic [NW-1:0]    tgt_ff;     // node that pop/remove takes out
   logic [CNT_W-1:0] cnt_ff;     // init count, clamped to NODES

   // init walk
   logic [NW-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0] rem_ff, rem_in;

   // per-list descriptors
   logic [NW-1:0]        head_ff  [NUM_LISTS];
   logic [NW-1:0]        tail_ff  [NUM_LISTS];
   logic [CNT_W-1:0]     count_ff [NUM_LISTS];
   logic [NUM_LISTS-1:0] busy_ff;             // list holds at least one node

   logic             desc_we;
   logic [NW-1:0]    new_head, new_tail;
   logic [CNT_W-1:0] new_count;
   logic             new_busy;

   logic [NW-1:0]    cur_head, cur_tail;
   logic [CNT_W-1:0] cur_count;
   logic             cur_busy;

   // link RAM ports
   logic          nx_we, pv_we;
   logic [NW-1:0] nx_addr, nx_data, pv_addr, pv_data;
   logic [NW-1:0] rd_addr, rd_next, rd_prev;

   // request decode
   logic             accept;
   logic [7:0]       nv;
   logic [1:0]       lv;
   logic [NW-1:0]    req_node;
   logic [LW-1:0]    req_lid;
   logic [CNT_W-1:0] req_cnt;

   // response
   logic          out_free;
   logic          finish;
   logic [NW-1:0] taken;
   logic          taken_ok;
   logic [NW-1:0] walk_nxt;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // One word in flight: the next request is read only after the last
   // write of this one has landed, so the link RAMs need no forwarding.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // node_index mod NODES and list_id mod NUM_LISTS by restoring subtraction
   always_comb begin
      nv = req_word.node_index;
      for (int k = 7; k >= 0; k--) begin
         if (32'(nv) >= (NODES << k)) begin
            nv = nv - 8'(NODES << k);
         end
      end
      lv = req_word.list_id;
      for (int k = 1; k >= 0; k--) begin
         if (32'(lv) >= (NUM_LISTS << k)) begin
            lv = lv - 2'(NUM_LISTS << k);
         end
      end
      req_node = NW'(nv);
      req_lid  = LW'(lv);
      req_cnt  = (32'(req_word.init_count) > NODES) ? CNT_W'(NODES) : req_word.init_count;
   end

   // Pop tail/head remove the current tail/head; read both links of that
   // node in the accept cycle so they are ready in the execute step.
   always_comb begin
      case (req_word.req_type)
         OP_POP_TAIL: rd_addr = tail_ff[req_lid];
         OP_POP_HEAD: rd_addr = head_ff[req_lid];
         default:     rd_addr = req_node;
      endcase
   end

   dlnl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_addr),
      .wr_data (nx_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_next)
   );

   dlnl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_addr),
      .wr_data (pv_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_prev)
   );

   assign cur_head  = head_ff[lid_ff];
   assign cur_tail  = tail_ff[lid_ff];
   assign cur_count = count_ff[lid_ff];
   assign cur_busy  = busy_ff[lid_ff];
   assign walk_nxt  = (ptr_ff == NW'(NODES - 1)) ? '0 : ptr_ff + 1'b1;

   // sequencer and list update; execute and walk steps wait for a free output slot
   always_comb begin
      state_in  = state_ff;
      desc_we   = 1'b0;
      new_head  = cur_head;
      new_tail  = cur_tail;
      new_count = cur_count;
      new_busy  = cur_busy;
      nx_we     = 1'b0;
      nx_addr   = cur_tail;
      nx_data   = node_ff;
      pv_we     = 1'b0;
      pv_addr   = node_ff;
      pv_data   = cur_tail;
      taken     = '0;
      taken_ok  = 1'b0;
      finish    = 1'b0;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               desc_we  = 1'b1;
               finish   = 1'b1;
               state_in = ST_IDLE;
               case (typ_ff)
                  OP_PUSH_TAIL: begin
                     if (!cur_busy) begin
                        new_head = node_ff;
                        new_busy = 1'b1;
                     end else begin
                        // next[tail] = node, prev[node] = tail
                        nx_we = 1'b1;
                        pv_we = 1'b1;
                     end
                     new_tail  = node_ff;
                     new_count = cnt_up(cur_count);
                  end
                  OP_PUSH_HEAD: begin
                     if (!cur_busy) begin
                        new_tail = node_ff;
                        new_busy = 1'b1;
                     end else begin
                        // prev[head] = node, next[node] = head
                        pv_we   = 1'b1;
                        pv_addr = cur_head;
                        pv_data = node_ff;
                        nx_we   = 1'b1;
                        nx_addr = node_ff;
                        nx_data = cur_head;
                     end
                     new_head  = node_ff;
                     new_count = cnt_up(cur_count);
                  end
                  OP_POP_TAIL, OP_POP_HEAD, OP_REMOVE: begin
                     if (cur_busy) begin
                        taken     = tgt_ff;
                        taken_ok  = 1'b1;
                        new_count = cnt_down(cur_count);
                        if (tgt_ff == cur_head && tgt_ff == cur_tail) begin
                           new_busy = 1'b0;
                        end else if (tgt_ff == cur_head) begin
                           new_head = rd_next;
                        end else if (tgt_ff == cur_tail) begin
                           new_tail = rd_prev;
                        end else begin
                           // middle node: splice its neighbors together
                           pv_we   = 1'b1;
                           pv_addr = rd_next;
                           pv_data = rd_prev;
                           nx_we   = 1'b1;
                           nx_addr = rd_prev;
                           nx_data = rd_next;
                        end
                     end
                  end
                  OP_INIT: begin
                     ptr_in = node_ff;
                     rem_in = cnt_ff - 1'b1;
                     if (cnt_ff == '0) begin
                        new_busy  = 1'b0;
                        new_count = '0;
                     end else begin
                        new_head  = node_ff;
                        new_tail  = node_ff;
                        new_busy  = 1'b1;
                        new_count = CNT_W'(1);
                        if (cnt_ff > CNT_W'(1)) begin
                           finish   = 1'b0;
                           state_in = ST_WALK;
                        end
                     end
                  end
                  default: begin
                     // unused code: list untouched, report its state
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (out_free) begin
               // append the next consecutive node (wraps at NODES)
               desc_we   = 1'b1;
               nx_we     = 1'b1;
               nx_addr   = ptr_ff;
               nx_data   = walk_nxt;
               pv_we     = 1'b1;
               pv_addr   = walk_nxt;
               pv_data   = ptr_ff;
               new_tail  = walk_nxt;
               new_count = cnt_up(cur_count);
               ptr_in    = walk_nxt;
               rem_in    = rem_ff - 1'b1;
               if (rem_ff == CNT_W'(1)) begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: holds a finished word while the next request is taken
   always_comb begin
      rsp_word_in              = rsp_word_ff;
      rsp_word_in.result_node  = NODE_W'(taken);
      rsp_word_in.result_valid = taken_ok;
      rsp_word_in.list_count   = new_count;
      rsp_word_in.list_empty   = !new_busy;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (desc_we) begin
            count_ff[lid_ff] <= new_count;
            busy_ff[lid_ff]  <= new_busy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         typ_ff  <= req_word.req_type;
         lid_ff  <= req_lid;
         node_ff <= req_node;
         tgt_ff  <= rd_addr;
         cnt_ff  <= req_cnt;
      end
      if (desc_we) begin
         head_ff[lid_ff] <= new_head;
         tail_ff[lid_ff] <= new_tail;
      end
      if (finish) begin
         rsp_word_ff <= rsp_word_in;
      end
      ptr_ff <= ptr_in;
      rem_ff <= rem_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/core/dlnl_check.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dlnl_check import dlnl_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // stalled result word holds
   `DLNL_CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "rsp word changed under stall")

   // no node reported means node field reads zero
   `DLNL_CHK_NOW(a_node_zero, clock, reset, rsp_valid && !rsp_word.result_valid, rsp_word.result_node == '0, "result_node set without result_valid")

   // one request at a time
   `DLNL_CHK_NEXT(a_one_busy, clock, reset, req_valid && !req_stall, req_stall, "second request taken while busy")

   // a new result only ends a busy stretch
   `DLNL_CHK_NOW(a_rsp_src, clock, reset, $rose(rsp_valid), $past(req_stall), "result word without work in progress")

endmodule

bind doubly_linked_node_list_manager dlnl_check u_dlnl_check (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

// Checks the linked-list manager against an in-bench mirror of its lists.
// Every accepted request word updates the mirror and queues the response word
// the block owes; the response checker compares arrivals in order, field by field.
// The mirror also tracks which link entries were ever written, so no request
// is issued that would make the block follow a link that holds no value yet.

module tb_top;
   import dlnl_pkg::*;

   localparam int NODES = DLNL_NODES;
   localparam int LISTS = DLNL_LISTS;

   // request codes the block leaves unused
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   req_word_type req_word  = '0;
   logic         rsp_stall = 1'b0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   doubly_linked_node_list_manager u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Mirror of the list state
   // ------------------------------------------------------------------
   logic [NODE_W-1:0] fwd_link  [NODES];
   logic [NODE_W-1:0] back_link [NODES];
   bit                fwd_set   [NODES];   // fwd_link entry has been written
   bit                back_set  [NODES];   // back_link entry has been written
   logic [NODE_W-1:0] head_of   [LISTS];
   logic [NODE_W-1:0] tail_of   [LISTS];
   logic [CNT_W-1:0]  size_of   [LISTS] = '{default: '0};
   bit                occupied  [LISTS];
   int                fresh_next [LISTS];  // rolling pointer into each list's node region

   rsp_word_type pending_rsps [$];          // response words owed, oldest first

   int  errors      = 0;
   int  words_sent  = 0;
   int  rsp_checked = 0;
   int  rebuilds    = 0;
   int  peak_count  = 0;
   bit  calm        = 1'b0;   // no idling on either side while set
   int  hold_left   = 0;      // cycles the response side still has to stall

   function automatic void append_node(int l, logic [NODE_W-1:0] n);
      if (!occupied[l]) begin
         head_of[l]  = n;
         tail_of[l]  = n;
         occupied[l] = 1'b1;
      end else begin
         fwd_link[tail_of[l]] = n;
         fwd_set[tail_of[l]]  = 1'b1;
         back_link[n]         = tail_of[l];
         back_set[n]          = 1'b1;
         tail_of[l]           = n;
      end
      if (size_of[l] != CNT_MAX) size_of[l] = size_of[l] + 1'b1;
   endfunction

   function automatic void prepend_node(int l, logic [NODE_W-1:0] n);
      if (!occupied[l]) begin
         head_of[l]  = n;
         tail_of[l]  = n;
         occupied[l] = 1'b1;
      end else begin
         back_link[head_of[l]] = n;
         back_set[head_of[l]]  = 1'b1;
         fwd_link[n]           = head_of[l];
         fwd_set[n]            = 1'b1;
         head_of[l]            = n;
      end
      if (size_of[l] != CNT_MAX) size_of[l] = size_of[l] + 1'b1;
   endfunction

   // Takes n out of a non-empty list. A node that is not a member is spliced
   // as if it sat in the middle, using whatever its own links say.
   function automatic void unlink_node(int l, logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] succ, pred;
      if (n == head_of[l] && n == tail_of[l]) begin
         occupied[l] = 1'b0;
      end else if (n == head_of[l]) begin
         head_of[l] = fwd_link[n];
      end else if (n == tail_of[l]) begin
         tail_of[l] = back_link[n];
      end else begin
         succ = fwd_link[n];
         pred = back_link[n];
         back_link[succ] = pred;
         back_set[succ]  = 1'b1;
         fwd_link[pred]  = succ;
         fwd_set[pred]   = 1'b1;
      end
      if (size_of[l] != '0) size_of[l] = size_of[l] - 1'b1;
   endfunction

   // True when the word would make the block follow a link never written.
   function automatic bit would_read_unwritten(req_word_type w);
      int l;
      logic [NODE_W-1:0] n;
      l = w.list_id;
      if (!occupied[l]) return 1'b0;
      case (w.req_type)
         OP_POP_TAIL: n = tail_of[l];
         OP_POP_HEAD: n = head_of[l];
         OP_REMOVE:   n = w.node_index;
         default:     return 1'b0;
      endcase
      if (n == head_of[l] && n == tail_of[l]) return 1'b0;
      if (n == head_of[l]) return !fwd_set[n];
      if (n == tail_of[l]) return !back_set[n];
      return !(fwd_set[n] && back_set[n]);
   endfunction

   // Applies one request word to the mirror and returns the response it owes.
   function automatic rsp_word_type predict_response(req_word_type w);
      rsp_word_type r;
      int l, c, i;
      r = '0;
      l = w.list_id;
      case (w.req_type)
         OP_PUSH_TAIL: append_node(l, w.node_index);
         OP_PUSH_HEAD: prepend_node(l, w.node_index);
         OP_POP_TAIL, OP_POP_HEAD, OP_REMOVE: begin
            if (occupied[l]) begin
               if (w.req_type == OP_POP_TAIL)      r.result_node = tail_of[l];
               else if (w.req_type == OP_POP_HEAD) r.result_node = head_of[l];
               else                                r.result_node = w.node_index;
               r.result_valid = 1'b1;
               unlink_node(l, r.result_node);
            end
         end
         OP_INIT: begin
            occupied[l] = 1'b0;
            size_of[l]  = '0;
            c = (w.init_count > NODES) ? NODES : w.init_count;
            for (i = 0; i < c; i++) append_node(l, w.node_index + NODE_W'(i));
         end
         default: ;
      endcase
      r.list_count = size_of[l];
      r.list_empty = !occupied[l];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Each list draws its fresh nodes from its own quarter of the pool.
   function automatic logic [NODE_W-1:0] fresh_node(int l);
      fresh_next[l] = (fresh_next[l] + 1) % 64;
      return NODE_W'(l * 64 + fresh_next[l]);
   endfunction

   // Walks a few steps in from the head to find a likely member.
   function automatic logic [NODE_W-1:0] pick_member(int l);
      logic [NODE_W-1:0] n;
      int k, i;
      if (!occupied[l]) return NODE_W'($urandom);
      n = head_of[l];
      k = $urandom_range(0, (size_of[l] > 16) ? 15 : ((size_of[l] == 0) ? 0 : size_of[l] - 1));
      for (i = 0; i < k && fwd_set[n]; i++) n = fwd_link[n];
      return n;
   endfunction

   // Mostly well-formed list traffic; a slice of noise on top.
   function automatic req_word_type random_request();
      req_word_type w;
      int l, pick, span;
      l            = $urandom_range(0, LISTS - 1);
      pick         = $urandom_range(0, 99);
      w.list_id    = LID_W'(l);
      w.node_index = NODE_W'($urandom);
      w.init_count = CNT_W'($urandom);
      if (pick < 22) begin
         w.req_type   = OP_PUSH_TAIL;
         w.node_index = fresh_node(l);
      end else if (pick < 40) begin
         w.req_type   = OP_PUSH_HEAD;
         w.node_index = fresh_node(l);
      end else if (pick < 54) begin
         w.req_type = OP_POP_TAIL;
      end else if (pick < 68) begin
         w.req_type = OP_POP_HEAD;
      end else if (pick < 84) begin
         w.req_type   = OP_REMOVE;
         w.node_index = pick_member(l);
      end else if (pick < 90) begin
         w.req_type   = OP_INIT;
         w.node_index = NODE_W'(l * 64 + $urandom_range(0, 63));
         span = $urandom_range(0, 99);
         if (span < 80)      w.init_count = CNT_W'($urandom_range(0, 12));
         else if (span < 97) w.init_count = CNT_W'($urandom_range(13, 64));
         else                w.init_count = CNT_W'($urandom_range(200, 511));
      end else if (pick < 94) begin
         w.req_type = OP_REMOVE;                  // any node, member or not
      end else if (pick < 97) begin
         w.req_type = $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
      end else begin
         w.req_type = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      return w;
   endfunction

   // Offers one request word from a falling edge and returns on the falling
   // edge after acceptance, with valid still high; the caller either offers
   // the next word or lowers valid.
   task automatic send_word(input req_word_type w);
      rsp_word_type owed;
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      // a take that would chase an unwritten link becomes a plain push
      if (would_read_unwritten(w)) w.req_type = OP_PUSH_TAIL;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      owed = predict_response(w);
      pending_rsps.push_back(owed);
      words_sent++;
      if (w.req_type == OP_INIT) rebuilds++;
      if (owed.list_count > peak_count) peak_count = owed.list_count;
      @(negedge clock);
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input int l,
                          input int n, input int cnt);
      req_word_type w;
      w.req_type   = op;
      w.list_id    = LID_W'(l);
      w.node_index = NODE_W'(n);
      w.init_count = CNT_W'(cnt);
      send_word(w);
   endtask

   // Changes the idling mode at a rising edge, away from the stall driver.
   task automatic set_calm(input bit v);
      req_valid <= 1'b0;
      @(posedge clock);
      calm = v;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      int spins;
      req_valid <= 1'b0;
      for (spins = 0; spins < 50000 && pending_rsps.size() != 0; spins++) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_edges();
      // takes on an empty list give no node
      send_op(OP_POP_TAIL, 0, 0, 0);
      send_op(OP_POP_HEAD, 0, 255, 511);
      send_op(OP_REMOVE, 0, 5, 0);
      // spare codes on empty lists
      send_op(OP_SPARE_6, 1, $urandom, $urandom);
      send_op(OP_SPARE_7, 2, $urandom, $urandom);
      // both ends, extreme node numbers
      send_op(OP_PUSH_TAIL, 0, 0, 0);
      send_op(OP_PUSH_TAIL, 0, 255, 0);
      send_op(OP_PUSH_HEAD, 0, 128, 0);
      send_op(OP_POP_TAIL, 0, 0, 0);
      send_op(OP_POP_HEAD, 0, 0, 0);
      send_op(OP_REMOVE, 0, 0, 0);          // last node, list goes empty
      // init that wraps past the top of the pool, then middle/head/tail removes
      send_op(OP_INIT, 2, 250, 10);
      send_op(OP_REMOVE, 2, 252, 0);
      send_op(OP_REMOVE, 2, 250, 0);
      send_op(OP_REMOVE, 2, 3, 0);
      // zero-length init, then oversized init clamps to the pool size
      send_op(OP_INIT, 1, 7, 0);
      send_op(OP_INIT, 3, 0, 300);
      send_op(OP_SPARE_6, 3, $urandom, $urandom);
      send_op(OP_PUSH_TAIL, 3, 1, 0);       // node already in the list
      // foreign-node removes drive the count down to zero and hold it there
      send_op(OP_PUSH_TAIL, 0, 10, 0);
      send_op(OP_PUSH_TAIL, 0, 11, 0);
      send_op(OP_REMOVE, 0, 100, 0);
      send_op(OP_REMOVE, 0, 101, 0);
      send_op(OP_REMOVE, 0, 102, 0);
      send_op(OP_POP_HEAD, 0, 0, 0);
      send_op(OP_SPARE_7, 0, $urandom, $urandom);
   endtask

   task automatic test_count_saturation();
      int i;
      send_op(OP_INIT, 1, $urandom, 256);
      // pushes past 511 must hold the count at its ceiling
      for (i = 0; i < 260; i++)
         send_op($urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD, 1, $urandom, $urandom);
      for (i = 0; i < 10; i++) begin
         case ($urandom_range(0, 2))
            0:       send_op(OP_POP_TAIL, 1, $urandom, $urandom);
            1:       send_op(OP_POP_HEAD, 1, $urandom, $urandom);
            default: send_op(OP_REMOVE, 1, pick_member(1), $urandom);
         endcase
      end
   endtask

   // Response side stalls for a long stretch while words keep coming, so the
   // block backs up and stalls its request side.
   task automatic test_output_hold();
      int i;
      req_valid <= 1'b0;
      @(posedge clock);
      hold_left = 250;
      calm      = 1'b1;
      @(negedge clock);
      for (i = 0; i < 60; i++) send_word(random_request());
      set_calm(1'b0);
   endtask

   task automatic test_drain_pause();
      int r, i;
      for (r = 0; r < 2; r++) begin
         for (i = 0; i < 30; i++) send_word(random_request());
         wait_for_drain();
      end
   endtask

   task automatic test_steady_burst();
      int i;
      set_calm(1'b1);
      for (i = 0; i < 250; i++) send_word(random_request());
      set_calm(1'b0);
   endtask

   task automatic test_random_traffic();
      int i;
      for (i = 0; i < 780; i++) send_word(random_request());
   endtask

   // ------------------------------------------------------------------
   // Response side: stall driver and checker
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 33);
      end
   end

   function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                       logic [CNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: response word with none expected: expected none, actual %p",
                     $time, rsp_word);
            errors++;
         end else begin
            want = pending_rsps.pop_front();
            rsp_checked++;
            check_field("result_node", want.result_node, rsp_word.result_node);
            check_field("result_valid", want.result_valid, rsp_word.result_valid);
            check_field("list_count", want.list_count, rsp_word.list_count);
            check_field("list_empty", want.list_empty, rsp_word.list_empty);
         end
      end
   end

   // ------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_edges();
      test_count_saturation();
      test_output_hold();
      test_drain_pause();
      test_steady_burst();
      test_random_traffic();

      wait_for_drain();
      repeat (20) @(posedge clock);   // catch any stray response words
      if (pending_rsps.size() != 0) begin
         $display("%0t: %0d response words never arrived: expected %p, actual none",
                  $time, pending_rsps.size(), pending_rsps[0]);
         errors += pending_rsps.size();
      end

      $display("Summary: %0d request words, %0d response words compared on %0d lists;",
               words_sent, rsp_checked, LISTS);
      $display("  %0d list rebuilds, peak count %0d, long output stall and full drain done",
               rebuilds, peak_count);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("%0t: run timed out with %0d response words outstanding",
               $time, pending_rsps.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
